[rtl/tlpq_pkg.sv]
// Shared types and constants of the three-level priority queue.
// No dependencies; used by every file under rtl except tlpq_ram.
package tlpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = 3;
  localparam int QIDX_W      = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = QIDX_W + PTR_W;
  localparam int NAME_W      = 32;
  localparam int AGE_W       = 8;
  localparam int REC_W       = NAME_W + AGE_W;

  localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [2:0] CLASS_URGENT    = 3'd1;
  localparam logic [2:0] CLASS_IMPORTANT = 3'd2;
  localparam logic [2:0] CLASS_STANDARD  = 3'd3;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_e;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [AGE_W-1:0]  age;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    rec_t              wdata;
  } ram_req_t;

  typedef struct packed {
    logic        strobe;
    status_e     status;
    logic        rec_valid;
    logic [1:0]  cls;
  } res_t;

endpackage

[rtl/tlpq_ram.sv]
// Single-port synchronous RAM, registered read data.
// Generic; no package dependency.
module tlpq_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tlpq_ctrl.sv]
// Queue control: read/write pointers, fill counts, class selection, status.
// Depends on tlpq_pkg; drives the request of tlpq_ram.
module tlpq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        action_i,
  input  logic [2:0]                  priority_class_i,
  input  logic [tlpq_pkg::NAME_W-1:0] name_ref_i,
  input  logic [tlpq_pkg::AGE_W-1:0]  person_age_i,
  output tlpq_pkg::ram_req_t          ram_req_o,
  output tlpq_pkg::res_t              res_o
);

  logic [tlpq_pkg::PTR_W-1:0] rd_ptr_q [tlpq_pkg::NUM_QUEUES];
  logic [tlpq_pkg::PTR_W-1:0] rd_ptr_d [tlpq_pkg::NUM_QUEUES];
  logic [tlpq_pkg::PTR_W-1:0] wr_ptr_q [tlpq_pkg::NUM_QUEUES];
  logic [tlpq_pkg::PTR_W-1:0] wr_ptr_d [tlpq_pkg::NUM_QUEUES];
  logic [tlpq_pkg::CNT_W-1:0] cnt_q    [tlpq_pkg::NUM_QUEUES];
  logic [tlpq_pkg::CNT_W-1:0] cnt_d    [tlpq_pkg::NUM_QUEUES];
  tlpq_pkg::res_t             res_q, res_d;

  logic                        cls_ok;
  logic [tlpq_pkg::QIDX_W-1:0] q_enq;
  logic [tlpq_pkg::QIDX_W-1:0] q_deq;
  logic                        found;

  function automatic logic [tlpq_pkg::PTR_W-1:0] next_ptr(
    input logic [tlpq_pkg::PTR_W-1:0] p
  );
    return (p == tlpq_pkg::LAST_PTR) ? '0 : p + tlpq_pkg::PTR_W'(1);
  endfunction

  always_comb begin
    cls_ok = (priority_class_i == tlpq_pkg::CLASS_URGENT) ||
             (priority_class_i == tlpq_pkg::CLASS_IMPORTANT) ||
             (priority_class_i == tlpq_pkg::CLASS_STANDARD);
    q_enq  = tlpq_pkg::QIDX_W'(priority_class_i - tlpq_pkg::CLASS_URGENT);

    found = 1'b1;
    if (cnt_q[0] != '0) begin
      q_deq = 2'd0;
    end else if (cnt_q[1] != '0) begin
      q_deq = 2'd1;
    end else if (cnt_q[2] != '0) begin
      q_deq = 2'd2;
    end else begin
      q_deq = 2'd0;
      found = 1'b0;
    end

    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;

    ram_req_o.we         = 1'b0;
    ram_req_o.re         = 1'b0;
    ram_req_o.addr       = {q_enq, wr_ptr_q[q_enq]};
    ram_req_o.wdata.name = name_ref_i;
    ram_req_o.wdata.age  = person_age_i;

    res_d.strobe    = accept_i;
    res_d.status    = tlpq_pkg::ST_OK;
    res_d.rec_valid = 1'b0;
    res_d.cls       = 2'd0;

    if (accept_i) begin
      if (action_i == tlpq_pkg::ACT_ENQUEUE) begin
        if (!cls_ok) begin
          res_d.status = tlpq_pkg::ST_BAD_CLASS;
        end else if (cnt_q[q_enq] == tlpq_pkg::FULL_COUNT) begin
          res_d.status = tlpq_pkg::ST_FULL;
        end else begin
          ram_req_o.we    = 1'b1;
          wr_ptr_d[q_enq] = next_ptr(wr_ptr_q[q_enq]);
          cnt_d[q_enq]    = cnt_q[q_enq] + tlpq_pkg::CNT_W'(1);
        end
      end else begin
        ram_req_o.addr = {q_deq, rd_ptr_q[q_deq]};
        if (!found) begin
          res_d.status = tlpq_pkg::ST_EMPTY;
        end else begin
          ram_req_o.re    = 1'b1;
          res_d.rec_valid = 1'b1;
          res_d.cls       = q_deq + 2'd1;
          rd_ptr_d[q_deq] = next_ptr(rd_ptr_q[q_deq]);
          cnt_d[q_deq]    = cnt_q[q_deq] - tlpq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tlpq_pkg::NUM_QUEUES; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
      res_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      res_q    <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/three_level_priority_queue.sv]
// Top level of the three-level strict priority queue.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_ram.
//
// Takes one command per clock: busy_o stays low, so a command is taken at
// every edge where start_i is high. Its result appears on the result ports
// with done_o high in the following cycle; a dequeued record is read from
// the shared record RAM, whose read data is registered. The result
// cannot be held off and must be taken in that cycle. Enqueue with class
// 1, 2 or 3 appends to that FIFO; dequeue returns the head of the highest
// non-empty class (1 first). All FIFOs are empty after reset.
module three_level_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        action_i,
  input  logic [2:0]                  priority_class_i,
  input  logic [tlpq_pkg::NAME_W-1:0] name_ref_i,
  input  logic [tlpq_pkg::AGE_W-1:0]  person_age_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        record_valid_o,
  output logic [tlpq_pkg::NAME_W-1:0] out_name_ref_o,
  output logic [tlpq_pkg::AGE_W-1:0]  out_age_o,
  output logic [1:0]                  out_class_o
);

  tlpq_pkg::ram_req_t ram_req;
  tlpq_pkg::res_t     res;
  tlpq_pkg::rec_t     rdata;
  logic               accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  tlpq_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (action_i),
    .priority_class_i (priority_class_i),
    .name_ref_i       (name_ref_i),
    .person_age_i     (person_age_i),
    .ram_req_o        (ram_req),
    .res_o            (res)
  );

  tlpq_ram #(
    .ADDR_W (tlpq_pkg::ADDR_W),
    .DATA_W (tlpq_pkg::REC_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (rdata)
  );

  assign done_o         = res.strobe;
  assign status_o       = res.status;
  assign record_valid_o = res.rec_valid;
  assign out_name_ref_o = res.rec_valid ? rdata.name : '0;
  assign out_age_o      = res.rec_valid ? rdata.age : '0;
  assign out_class_o    = res.cls;

endmodule

[rtl/tlpq_checker.sv]
// Port-level checks of three_level_priority_queue, bound to the top level.
// Depends on tlpq_pkg.
module tlpq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        action_i,
  input logic                        done_o,
  input logic [1:0]                  status_o,
  input logic                        record_valid_o,
  input logic [tlpq_pkg::NAME_W-1:0] out_name_ref_o,
  input logic [tlpq_pkg::AGE_W-1:0]  out_age_o,
  input logic [1:0]                  out_class_o
);

  a_done_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("no result after command transfer");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without command transfer");

  a_record_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    record_valid_o |-> (done_o && status_o == tlpq_pkg::ST_OK && out_class_o != 2'd0))
    else $error("record given with bad status or class");

  a_no_record_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !record_valid_o) |->
      (out_name_ref_o == '0 && out_age_o == '0 && out_class_o == 2'd0))
    else $error("record fields not zero without record");

  a_dequeue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == tlpq_pkg::ACT_DEQUEUE) |=>
      (status_o == tlpq_pkg::ST_OK || status_o == tlpq_pkg::ST_EMPTY))
    else $error("dequeue gave enqueue status");

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .action_i       (action_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .record_valid_o (record_valid_o),
  .out_name_ref_o (out_name_ref_o),
  .out_age_o      (out_age_o),
  .out_class_o    (out_class_o)
);

[bench/tb_three_level_priority_queue.sv]
// Self-checking bench for three_level_priority_queue: runs directed and random enqueue/dequeue
// commands and checks every result against a mirror of the three class FIFOs.
// Depends on tlpq_pkg and the RTL under rtl.
module tb_three_level_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int ITEM_TARGET = 440;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    logic [1:0]        status;
    logic              valid;
    logic [NAME_W-1:0] name;
    logic [AGE_W-1:0]  age;
    logic [1:0]        cls;
  } outcome_t;

  class record_queue_mirror;
    rec_t     held[NUM_QUEUES][$];
    outcome_t awaited[$];
    int       errors;

    function int pending();
      return awaited.size();
    endfunction

    function int total_held();
      return held[0].size() + held[1].size() + held[2].size();
    endfunction

    function void note_command(logic act, logic [2:0] cls, logic [NAME_W-1:0] name,
                               logic [AGE_W-1:0] age);
      outcome_t o;
      rec_t     r;
      int       q;
      o.status = ST_OK;
      o.valid  = 1'b0;
      o.name   = '0;
      o.age    = '0;
      o.cls    = '0;
      if (act == ACT_ENQUEUE) begin
        if (cls != CLASS_URGENT && cls != CLASS_IMPORTANT && cls != CLASS_STANDARD) begin
          o.status = ST_BAD_CLASS;
        end else begin
          q = int'(cls - CLASS_URGENT);
          if (held[q].size() >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            r.name = name;
            r.age  = age;
            held[q].push_back(r);
          end
        end
      end else begin
        q = -1;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
          if (held[i].size() != 0) q = i;
        end
        if (q < 0) begin
          o.status = ST_EMPTY;
        end else begin
          r       = held[q].pop_front();
          o.valid = 1'b1;
          o.name  = r.name;
          o.age   = r.age;
          o.cls   = 2'(q + 1);
        end
      end
      awaited.push_back(o);
    endfunction

    function int field_diff(string label, logic [NAME_W-1:0] want, logic [NAME_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, label, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, status %h name %h", $time, got.status, got.name);
        errors++;
        return;
      end
      want = awaited.pop_front();
      errors += field_diff("status", want.status, got.status);
      errors += field_diff("record_valid", want.valid, got.valid);
      errors += field_diff("out_name_ref", want.name, got.name);
      errors += field_diff("out_age", want.age, got.age);
      errors += field_diff("out_class", want.cls, got.cls);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              action_i;
  logic [2:0]        priority_class_i;
  logic [NAME_W-1:0] name_ref_i;
  logic [AGE_W-1:0]  person_age_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic              record_valid_o;
  logic [NAME_W-1:0] out_name_ref_o;
  logic [AGE_W-1:0]  out_age_o;
  logic [1:0]        out_class_o;

  record_queue_mirror mirror = new();
  int sent_items;
  int burst_left;

  three_level_priority_queue dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .priority_class_i (priority_class_i),
    .name_ref_i       (name_ref_i),
    .person_age_i     (person_age_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .record_valid_o   (record_valid_o),
    .out_name_ref_o   (out_name_ref_o),
    .out_age_o        (out_age_o),
    .out_class_o      (out_class_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results are checked before the transfer of this edge is noted
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        got.status = status_o;
        got.valid  = record_valid_o;
        got.name   = out_name_ref_o;
        got.age    = out_age_o;
        got.cls    = out_class_o;
        mirror.check_outcome(got);
      end
      if (start_i && busy_o === 1'b0) begin
        mirror.note_command(action_i, priority_class_i, name_ref_i, person_age_i);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic issue(logic act, logic [2:0] cls, logic [NAME_W-1:0] name,
                       logic [AGE_W-1:0] age);
    @(negedge clk_i);
    start_i          <= 1'b1;
    action_i         <= act;
    priority_class_i <= cls;
    name_ref_i       <= name;
    person_age_i     <= age;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sent_items++;
    pace();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [NAME_W-1:0] pick_name();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_class();
    int c;
    if ($urandom_range(0, 99) < 8) begin
      c = $urandom_range(0, 4);
      return (c == 0) ? 3'd0 : 3'(c + 3);
    end
    return 3'($urandom_range(CLASS_URGENT, CLASS_STANDARD));
  endfunction

  task automatic dequeue_one();
    issue(ACT_DEQUEUE, 3'($urandom), pick_name(), 8'($urandom));
  endtask

  task automatic run_directed();
    dequeue_one();
    issue(ACT_ENQUEUE, 3'd0, '1, 8'hff);
    issue(ACT_ENQUEUE, 3'd4, 32'h1234_5678, 8'h01);
    issue(ACT_ENQUEUE, 3'd7, 32'h8765_4321, 8'h80);
    issue(ACT_ENQUEUE, CLASS_STANDARD, '0, 8'h00);
    issue(ACT_ENQUEUE, CLASS_STANDARD, '1, 8'hff);
    issue(ACT_ENQUEUE, CLASS_IMPORTANT, 32'ha5a5_a5a5, 8'h7f);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      issue(ACT_ENQUEUE, CLASS_URGENT, (i % 2) ? '1 : 32'h5a5a_5a5a + i, 8'(i * 17));
    end
    issue(ACT_ENQUEUE, CLASS_URGENT, 32'hdead_beef, 8'hff);
    dequeue_one();
  endtask

  task automatic run_random();
    int n;
    int bias;
    logic [2:0] cls;
    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          n    = $urandom_range(10, 30);
          bias = $urandom_range(15, 85);
          repeat (n) begin
            if ($urandom_range(0, 99) < bias) dequeue_one();
            else issue(ACT_ENQUEUE, pick_class(), pick_name(), 8'($urandom));
          end
        end
        5, 6: begin
          cls = 3'($urandom_range(CLASS_URGENT, CLASS_STANDARD));
          n   = $urandom_range(4, 20);
          repeat (n) issue(ACT_ENQUEUE, cls, pick_name(), 8'($urandom));
        end
        7: begin
          n = mirror.total_held() + $urandom_range(1, 3);
          repeat (n) dequeue_one();
        end
        8: begin
          n = $urandom_range(4, 10);
          repeat (n) issue(1'($urandom), 3'($urandom), pick_name(), 8'($urandom));
        end
        default: wait_drained();
      endcase
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    action_i         = ACT_ENQUEUE;
    priority_class_i = '0;
    name_ref_i       = '0;
    person_age_i     = '0;
    sent_items       = 0;
    burst_left       = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tlpq_pkg.sv
rtl/tlpq_ram.sv
rtl/tlpq_ctrl.sv
rtl/three_level_priority_queue.sv
rtl/tlpq_checker.sv
bench/tb_three_level_priority_queue.sv
